// ----- rtl/u8e_pkg.sv -----
package u8e_pkg;

   localparam logic [31:0] Limit1 = 32'h0000_007f;
   localparam logic [31:0] Limit2 = 32'h0000_07ff;
   localparam logic [31:0] Limit3 = 32'h0000_ffff;
   localparam logic [31:0] Limit4 = 32'h001f_ffff;
   localparam logic [31:0] Limit5 = 32'h03ff_ffff;
   localparam logic [31:0] ByteOrderMark = 32'h0000_feff;

   localparam int MaxBytes = 6;
   localparam int IdxWidth = 3;

   localparam logic [IdxWidth-1:0] Len1 = 3'd1;
   localparam logic [IdxWidth-1:0] Len2 = 3'd2;
   localparam logic [IdxWidth-1:0] Len3 = 3'd3;
   localparam logic [IdxWidth-1:0] Len4 = 3'd4;
   localparam logic [IdxWidth-1:0] Len5 = 3'd5;
   localparam logic [IdxWidth-1:0] Len6 = 3'd6;

   localparam logic [1:0] ContPrefix = 2'b10;

   typedef logic [IdxWidth-1:0] len_type;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] seq;
      len_type                  len;
   } item_type;

   function automatic len_type seq_length(input logic [31:0] cp);
      len_type n;
      if (cp <= Limit1) begin
         n = Len1;
      end else if (cp <= Limit2) begin
         n = Len2;
      end else if (cp <= Limit3) begin
         n = Len3;
      end else if (cp <= Limit4) begin
         n = Len4;
      end else if (cp <= Limit5) begin
         n = Len5;
      end else begin
         n = Len6;
      end
      return n;
   endfunction

   // seq[0] is the lead byte, continuation bytes follow in send order
   function automatic item_type encode(input logic [31:0] cp);
      item_type it;
      logic [7:0] g0, g1, g2, g3, g4;
      g0 = {ContPrefix, cp[5:0]};
      g1 = {ContPrefix, cp[11:6]};
      g2 = {ContPrefix, cp[17:12]};
      g3 = {ContPrefix, cp[23:18]};
      g4 = {ContPrefix, cp[29:24]};
      it.len = seq_length(cp);
      it.seq = '0;
      case (it.len)
         Len1: begin
            it.seq[0] = {1'b0, cp[6:0]};
         end
         Len2: begin
            it.seq[0] = {3'b110, cp[10:6]};
            it.seq[1] = g0;
         end
         Len3: begin
            it.seq[0] = {4'b1110, cp[15:12]};
            it.seq[1] = g1;
            it.seq[2] = g0;
         end
         Len4: begin
            it.seq[0] = {5'b11110, cp[20:18]};
            it.seq[1] = g2;
            it.seq[2] = g1;
            it.seq[3] = g0;
         end
         Len5: begin
            it.seq[0] = {6'b111110, cp[25:24]};
            it.seq[1] = g3;
            it.seq[2] = g2;
            it.seq[3] = g1;
            it.seq[4] = g0;
         end
         Len6: begin
            it.seq[0] = {7'b1111110, cp[30]};
            it.seq[1] = g4;
            it.seq[2] = g3;
            it.seq[3] = g2;
            it.seq[4] = g1;
            it.seq[5] = g0;
         end
         default: begin
            it.seq = '0;
         end
      endcase
      return it;
   endfunction

endpackage

// ----- rtl/u8e_front.sv -----
module u8e_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_code_point,
   input  logic              q_full,
   output logic              q_push,
   output u8e_pkg::item_type q_item
);
   import u8e_pkg::*;

   logic drop;

   // byte-order mark and bit 31 set produce nothing
   assign drop      = (req_code_point == ByteOrderMark) || req_code_point[31];
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && !drop;
   assign q_item    = encode(req_code_point);

endmodule

// ----- rtl/u8e_queue.sv -----
module u8e_queue #(
   parameter int Depth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u8e_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output u8e_pkg::item_type head_item
);
   import u8e_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);

   item_type            mem [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign full       = (count_ff == DepthCnt);
   assign head_valid = (count_ff != '0);
   assign head_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("queue count out of range");

endmodule

// ----- rtl/u8e_back.sv -----
module u8e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  u8e_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_byte
);
   import u8e_pkg::*;

   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                last_ff, last_in;
   logic                load;
   logic                is_last;

   assign load    = (!valid_ff || !rsp_stall) && q_valid;
   assign is_last = (idx_ff == q_item.len - 1'b1);
   assign q_pop   = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (!valid_ff || !rsp_stall) begin
         valid_in = q_valid;
      end
      if (load) begin
         byte_in = q_item.seq[idx_ff];
         last_in = is_last;
         idx_in  = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

   a_idx_in_item: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> idx_ff < q_item.len)
      else $error("serializer index past item length");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> valid_ff && last_ff)
      else $error("item released without last byte");

   a_mid_item_held: assert property (@(posedge clock) disable iff (reset)
      idx_ff != '0 |-> q_valid)
      else $error("item left queue mid sequence");

endmodule

// ----- rtl/utf8_code_point_encoder.sv -----
// channel   ports                                   direction
// req       req_valid req_stall req_code_point      in
// rsp       rsp_valid rsp_stall rsp_out_byte
//           rsp_last_byte                           out
//
// one code point transfer per cycle while the queue has room
// an n-byte code point holds the serializer for n bytes, one per cycle if not stalled
// first byte passes the queue, then the output register, after the req transfer
// reset is synchronous and empties the queue and the output register
// rsp_stall holds the output byte and fills the queue, then req_stall rises
module utf8_code_point_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_code_point,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);
   import u8e_pkg::*;

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   item_type push_item;
   item_type head_item;

   u8e_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   u8e_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   u8e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (head_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// ----- test/utf8_code_point_encoder_check.sv -----
module utf8_code_point_encoder_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_code_point,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_byte,
   output int          owed_bytes,
   output int          byte_errors
);

   timeunit 1ns;
   timeprecision 1ps;

   import u8e_pkg::*;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last;
   } utf8_byte_type;

   utf8_byte_type owed_q[$];
   utf8_byte_type oldest;

   function automatic int utf8_length(input logic [31:0] cp);
      if (cp <= Limit1) return 1;
      if (cp <= Limit2) return 2;
      if (cp <= Limit3) return 3;
      if (cp <= Limit4) return 4;
      if (cp <= Limit5) return 5;
      return 6;
   endfunction

   // queue the bytes one code point should produce, lead byte first
   task automatic encode_code_point(input logic [31:0] cp);
      int n;
      logic [31:0] bits;
      utf8_byte_type b;
      if (cp == ByteOrderMark || cp[31]) begin
         return;
      end
      n = utf8_length(cp);
      for (int k = 0; k < n; k++) begin
         bits = cp >> (6 * (n - 1 - k));
         if (k == 0 && n == 1) begin
            b.code_byte = {1'b0, bits[6:0]};
         end else if (k == 0) begin
            b.code_byte = (8'hff << (8 - n)) | (bits[7:0] & (8'h7f >> n));
         end else begin
            b.code_byte = {2'b10, bits[5:0]};
         end
         b.last = (k == n - 1);
         owed_q.push_back(b);
      end
   endtask

   task automatic report_mismatch(input string what, input utf8_byte_type want);
      byte_errors++;
      if (byte_errors <= 10) begin
         $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $realtime, what, want.code_byte, want.last, rsp_out_byte, rsp_last_byte);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_q.delete();
         owed_bytes = 0;
         byte_errors = 0;
      end else begin
         // results first: a byte never leaves in the cycle of its own transfer
         if (rsp_valid && !rsp_stall) begin
            if (owed_q.size() == 0) begin
               report_mismatch("unexpected byte", '0);
            end else begin
               oldest = owed_q.pop_front();
               if (oldest.code_byte !== rsp_out_byte || oldest.last !== rsp_last_byte) begin
                  report_mismatch("byte mismatch", oldest);
               end
            end
         end
         if (req_valid && !req_stall) begin
            encode_code_point(req_code_point);
         end
         owed_bytes = owed_q.size();
      end
   end

endmodule

// ----- test/utf8_code_point_encoder_test.sv -----
module utf8_code_point_encoder_test;

   timeunit 1ns;
   timeprecision 1ps;

   import u8e_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int IdlePct = 16;
   localparam int HoldCycles = 80;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_code_point;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;

   int owed_bytes;
   int byte_errors;
   int cycle_count = 0;

   // sender writes at the falling edge; receiver reads hold_kick, rsp_quiet at the rising edge
   int hold_kick = 0;
   bit rsp_quiet = 1'b0;
   bit req_quiet = 1'b0;

   logic [31:0] corner_points[$] = '{
      32'h0000_0000, 32'h0000_007f, 32'h0000_0080, 32'h0000_07ff, 32'h0000_0800,
      32'h0000_feff, 32'h0000_fefe, 32'h0000_ff00, 32'h0000_ffff, 32'h0001_0000,
      32'h001f_ffff, 32'h0020_0000, 32'h03ff_ffff, 32'h0400_0000, 32'h7fff_ffff,
      32'h5555_5555, 32'h2aaa_aaaa, 32'h8000_0000, 32'hffff_ffff, 32'haaaa_aaaa,
      32'h0000_0041, 32'h0000_20ac
   };
   logic [31:0] band_low[6]  = '{32'h0, 32'h80, 32'h800, 32'h1_0000, 32'h20_0000, 32'h400_0000};
   logic [31:0] band_high[6] = '{32'h7f, 32'h7ff, 32'hffff, 32'h1f_ffff, 32'h3ff_ffff,
                                 32'h7fff_ffff};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   utf8_code_point_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   utf8_code_point_encoder_check byte_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_byte  (rsp_last_byte),
      .owed_bytes     (owed_bytes),
      .byte_errors    (byte_errors)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, a long hold-off on request, quiet stretches
   initial begin
      int hold_left;
      int hold_seen;
      bit quiet;
      hold_left = 0;
      hold_seen = 0;
      quiet = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HoldCycles;
         end
         quiet = rsp_quiet;
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = !quiet && ($urandom_range(0, 99) < IdlePct);
         end
      end
   end

   task automatic send_code_point(input logic [31:0] cp);
      while (!req_quiet && $urandom_range(0, 99) < IdlePct) begin
         req_valid = 1'b0;
         req_code_point = $urandom;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_code_point = cp;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_code_point();
      int pick;
      int band;
      pick = $urandom_range(0, 99);
      band = $urandom_range(0, 5);
      if (pick < 4) return ByteOrderMark;
      if (pick < 12) return {1'b1, 31'($urandom)};
      if (pick < 20) return corner_points[$urandom_range(0, corner_points.size() - 1)];
      return $urandom_range(band_high[band], band_low[band]);
   endfunction

   task automatic wait_drained();
      req_valid = 1'b0;
      while (owed_bytes != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_code_point = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (corner_points[i]) begin
         send_code_point(corner_points[i]);
      end

      for (int i = 0; i < 250; i++) begin
         if (i == 60) begin
            hold_kick++;
         end
         if (i == 120) begin
            wait_drained();
         end
         req_quiet = (i >= 150 && i < 210);
         rsp_quiet = req_quiet;
         send_code_point(random_code_point());
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (byte_errors == 0 && owed_bytes == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
